### rtl/afr_pkg.sv
// Shared types and constants for the friend recommender block.
`timescale 1ns / 1ps

package afr_pkg;

    // Node ids travel as 4-bit values, so at most 16 nodes can ever be addressed.
    localparam int NODE_W    = 4;
    localparam int MAX_IDS   = 2 ** NODE_W;
    localparam int MAX_OUT   = 16;
    localparam int NFOUND_W  = $clog2(MAX_OUT + 1);
    localparam int MEM_AW    = 2 * NODE_W;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_RECO   = 2'd3
    } afr_cmd_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_DUP     = 3'd1,
        ST_MISSING = 3'd2,
        ST_FULL    = 3'd3,
        ST_RECO    = 3'd4,
        ST_NONE    = 3'd5
    } afr_status_t;

    typedef struct packed {
        afr_cmd_t            command;
        logic [NODE_W-1:0]   first_node;
        logic [NODE_W-1:0]   second_node;
    } afr_in_t;

    typedef struct packed {
        afr_status_t         status;
        logic [NODE_W-1:0]   suggested_node;
        logic                last_result;
    } afr_out_t;

    typedef struct packed {
        logic                wr_en;
        logic [MEM_AW-1:0]   wr_addr;
        logic [NODE_W-1:0]   wr_data;
        logic                rd_en;
        logic [MEM_AW-1:0]   rd_addr;
    } afr_mem_req_t;

    typedef struct packed {
        logic                push;
        afr_out_t            data;
    } afr_push_t;

endpackage

### rtl/afr_list_mem.sv
// Neighbor list storage: one write port and one registered read port.
`timescale 1ns / 1ps

module afr_list_mem
    import afr_pkg::*;
#(
    parameter int ADDR_W = 8
)
(
    input  logic                clk,
    input  afr_mem_req_t        req,
    output logic [NODE_W-1:0]   rd_data
);

    logic [NODE_W-1:0] mem [2 ** ADDR_W];
    logic [NODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[ADDR_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/afr_ctrl.sv
// Sequencer that scans neighbor lists one entry at a time through the shared compare path.
`timescale 1ns / 1ps

module afr_ctrl
    import afr_pkg::*;
#(
    parameter int NODES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  afr_in_t             cmd_req,
    input  logic                out_full,
    output afr_push_t           out_push,
    output afr_mem_req_t        mem_req,
    input  logic [NODE_W-1:0]   rd_data
);

    localparam int SW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int AW = 2 * SW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PH_FIND,
        PH_SHIFT,
        PH_MASK,
        PH_OUTER,
        PH_INNER
    } phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    afr_cmd_t               cmd_reg, cmd_next;
    logic [NODE_W-1:0]      a_reg, a_next;
    logic [NODE_W-1:0]      b_reg, b_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          src_cnt_reg, src_cnt_next;
    logic [CW-1:0]          nb_idx_reg, nb_idx_next;
    logic [SW-1:0]          nb_reg, nb_next;
    logic [NODES-1:0]       mask_reg, mask_next;
    logic [NFOUND_W-1:0]    nfound_reg, nfound_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [NODE_W-1:0]      pend_node_reg, pend_node_next;
    afr_status_t            fin_status_reg, fin_status_next;
    logic [NODE_W-1:0]      fin_node_reg, fin_node_next;
    logic [CW-1:0]          count_reg [NODES];
    logic [CW-1:0]          count_next [NODES];
    logic [NODES-1:0]       map_reg [NODES];
    logic [NODES-1:0]       map_next [NODES];

    logic                   a_ok;
    logic                   b_ok;
    logic [SW-1:0]          a_idx;
    logic [SW-1:0]          d_idx;
    logic [SW-1:0]          cnt_rd_addr;
    logic [CW-1:0]          cnt_rd;
    logic [CW-1:0]          idx_inc;
    logic [SW-1:0]          scan_node;
    logic [CW-1:0]          scan_slot;
    logic                   scan_end;
    logic                   cand;

    assign a_ok    = int'(a_reg) < NODES;
    assign b_ok    = int'(b_reg) < NODES;
    assign a_idx   = a_reg[SW-1:0];
    assign d_idx   = rd_data[SW-1:0];
    assign idx_inc = CW'(idx_reg + 1'b1);

    // The only count read: the source in most states, a fresh neighbor while walking.
    assign cnt_rd_addr = (state_reg == S_EVAL) ? d_idx : a_idx;
    assign cnt_rd      = count_reg[cnt_rd_addr];

    assign scan_node = (phase_reg == PH_INNER) ? nb_reg : a_idx;

    always_comb
    begin
        unique case (phase_reg)
            PH_OUTER:
            begin
                scan_slot = nb_idx_reg;
                scan_end  = (nb_idx_reg == src_cnt_reg);
            end
            PH_SHIFT:
            begin
                scan_slot = idx_inc;
                scan_end  = (idx_inc == cnt_reg);
            end
            default:
            begin
                scan_slot = idx_reg;
                scan_end  = (idx_reg == cnt_reg);
            end
        endcase
    end

    assign cand = (int'(nfound_reg) < MAX_OUT) && (rd_data != a_reg)
                  && !mask_reg[d_idx] && !map_reg[a_idx][d_idx];

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        src_cnt_next    = src_cnt_reg;
        nb_idx_next     = nb_idx_reg;
        nb_next         = nb_reg;
        mask_next       = mask_reg;
        nfound_next     = nfound_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        fin_status_next = fin_status_reg;
        fin_node_next   = fin_node_reg;
        count_next      = count_reg;
        map_next        = map_reg;

        mem_req         = '0;
        mem_req.rd_addr = MEM_AW'({scan_node, scan_slot[SW-1:0]});
        out_push        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd_req.command;
                    a_next     = cmd_req.first_node;
                    b_next     = cmd_req.second_node;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                fin_node_next = '0;
                idx_next      = '0;
                cnt_next      = cnt_rd;
                unique case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        if (a_ok)
                        begin
                            count_next[a_idx] = '0;
                        end
                        fin_status_next = ST_DONE;
                        state_next      = S_FINISH;
                    end
                    CMD_ADD, CMD_REMOVE:
                    begin
                        if (a_ok && b_ok)
                        begin
                            phase_next = PH_FIND;
                            state_next = S_READ;
                        end
                        else
                        begin
                            fin_status_next = (cmd_reg == CMD_ADD) ? ST_FULL : ST_MISSING;
                            state_next      = S_FINISH;
                        end
                    end
                    CMD_RECO:
                    begin
                        if (a_ok)
                        begin
                            src_cnt_next    = cnt_rd;
                            mask_next       = '0;
                            nfound_next     = '0;
                            pend_valid_next = 1'b0;
                            phase_next      = PH_MASK;
                            state_next      = S_READ;
                        end
                        else
                        begin
                            fin_status_next = ST_NONE;
                            state_next      = S_FINISH;
                        end
                    end
                endcase
            end

            S_READ:
            begin
                if (scan_end)
                begin
                    unique case (phase_reg)
                        PH_FIND:
                        begin
                            state_next = S_FINISH;
                            if (cmd_reg == CMD_REMOVE)
                            begin
                                fin_status_next = ST_MISSING;
                            end
                            else if (cnt_reg == CW'(NODES))
                            begin
                                fin_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en     = 1'b1;
                                mem_req.wr_addr   = MEM_AW'({a_idx, cnt_reg[SW-1:0]});
                                mem_req.wr_data   = b_reg;
                                count_next[a_idx] = CW'(cnt_reg + 1'b1);
                                fin_status_next   = ST_DONE;
                            end
                        end
                        PH_SHIFT:
                        begin
                            count_next[a_idx] = CW'(cnt_reg - 1'b1);
                            fin_status_next   = ST_DONE;
                            state_next        = S_FINISH;
                        end
                        PH_MASK:
                        begin
                            nb_idx_next = '0;
                            phase_next  = PH_OUTER;
                        end
                        PH_OUTER:
                        begin
                            // The held candidate becomes the final result.
                            fin_status_next = pend_valid_reg ? ST_RECO : ST_NONE;
                            fin_node_next   = pend_valid_reg ? pend_node_reg : '0;
                            state_next      = S_FINISH;
                        end
                        PH_INNER:
                        begin
                            nb_idx_next = CW'(nb_idx_reg + 1'b1);
                            phase_next  = PH_OUTER;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    state_next    = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_READ;
                unique case (phase_reg)
                    PH_FIND:
                    begin
                        if (rd_data == b_reg)
                        begin
                            if (cmd_reg == CMD_ADD)
                            begin
                                fin_status_next = ST_DUP;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                phase_next = PH_SHIFT;
                            end
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end
                    PH_SHIFT:
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = MEM_AW'({a_idx, idx_reg[SW-1:0]});
                        mem_req.wr_data = rd_data;
                        idx_next        = idx_inc;
                    end
                    PH_MASK:
                    begin
                        mask_next[d_idx] = 1'b1;
                        idx_next         = idx_inc;
                    end
                    PH_OUTER:
                    begin
                        nb_next    = d_idx;
                        cnt_next   = cnt_rd;
                        idx_next   = '0;
                        phase_next = PH_INNER;
                    end
                    PH_INNER:
                    begin
                        if (cand)
                        begin
                            if (pend_valid_reg && out_full)
                            begin
                                // Read data stays in the memory register while we wait.
                                state_next = S_EVAL;
                            end
                            else
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_push.push                = 1'b1;
                                    out_push.data.status         = ST_RECO;
                                    out_push.data.suggested_node = pend_node_reg;
                                    out_push.data.last_result    = 1'b0;
                                end
                                pend_valid_next        = 1'b1;
                                pend_node_next         = rd_data;
                                map_next[a_idx][d_idx] = 1'b1;
                                nfound_next            = NFOUND_W'(nfound_reg + 1'b1);
                                idx_next               = idx_inc;
                            end
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_FINISH:
            begin
                if (!out_full)
                begin
                    out_push.push                = 1'b1;
                    out_push.data.status         = fin_status_reg;
                    out_push.data.suggested_node = fin_node_reg;
                    out_push.data.last_result    = 1'b1;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_FIND;
            cmd_reg        <= CMD_CLEAR;
            a_reg          <= '0;
            b_reg          <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            src_cnt_reg    <= '0;
            nb_idx_reg     <= '0;
            nb_reg         <= '0;
            mask_reg       <= '0;
            nfound_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_node_reg  <= '0;
            fin_status_reg <= ST_DONE;
            fin_node_reg   <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                count_reg[i] <= '0;
                map_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            src_cnt_reg    <= src_cnt_next;
            nb_idx_reg     <= nb_idx_next;
            nb_reg         <= nb_next;
            mask_reg       <= mask_next;
            nfound_reg     <= nfound_next;
            pend_valid_reg <= pend_valid_next;
            pend_node_reg  <= pend_node_next;
            fin_status_reg <= fin_status_next;
            fin_node_reg   <= fin_node_next;
            count_reg      <= count_next;
            map_reg        <= map_next;
        end
    end

endmodule

### rtl/adjacency_friend_recommender.sv
// Clear touches no list. Add and remove scan the source list entry by entry, and an add stops
// early on a duplicate. Recommend scans the source list, then each entry of each neighbor's list,
// since every entry goes through the one registered list memory read port.
// One request at a time; the next is taken once the final result is queued, and a result that
// waits on a full output register stalls the sequencer. Reset clears counts and marks at once.
`timescale 1ns / 1ps

module adjacency_friend_recommender
    import afr_pkg::*;
#(
    parameter int NUM_NODES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  afr_in_t     cmd_req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output afr_out_t    rsp
);

    // Ids above the 4-bit range can never be named, so storage stops there.
    localparam int NODES_USED = (NUM_NODES < MAX_IDS) ? NUM_NODES : MAX_IDS;
    localparam int LIST_AW    = 2 * $clog2(NODES_USED);

    afr_mem_req_t       mem_req;
    logic [NODE_W-1:0]  rd_data;
    afr_push_t          out_push;
    logic               out_full;
    logic               rsp_valid_reg;
    afr_out_t           rsp_reg;

    assign out_full = rsp_valid_reg && !rsp_ready;

    afr_list_mem #(
        .ADDR_W (LIST_AW)
    ) u_list_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    afr_ctrl #(
        .NODES (NODES_USED)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_req   (cmd_req),
        .out_full  (out_full),
        .out_push  (out_push),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    // Output register decouples the sequencer from a stalled consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_push.push)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push.push)
        begin
            rsp_reg <= out_push.data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### bench/tb_top.sv
// Self-checking testbench for the friends-of-friends recommender block.
`timescale 1ns / 1ps

module tb_top;
    import afr_pkg::*;

    localparam int NODES       = 16;
    localparam int TARGET_REQS = 210;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AFTER  = 40;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    afr_in_t  cmd_req   = '0;
    logic     cmd_ready;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    afr_out_t rsp;

    adjacency_friend_recommender #(
        .NUM_NODES(NODES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_req  (cmd_req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    // Graph as the block should hold it.
    logic [NODE_W-1:0] nbr_ids [NODES][NODES];
    int                nbr_cnt [NODES];
    bit                already_suggested [NODES][NODES];

    afr_in_t  cmd_backlog [$];
    afr_out_t due_answers [$];

    // Link picture kept by the request generator so that removals can hit real links.
    bit gen_link [NODES][NODES];

    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    int   send_gap  = 0;
    int   rsp_wait  = 0;
    bit   send_steady = 1'b0;
    bit   rsp_steady  = 1'b0;
    bit   hold_done   = 1'b0;
    int   issued      = 0;
    int   error_count = 0;
    int   results_checked = 0;
    int   ids_suggested   = 0;
    int   idle_cycles     = 0;
    int   cmd_seen [4];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_linked(int src, int dst);
        for (int i = 0; i < nbr_cnt[src]; i++)
            if (int'(nbr_ids[src][i]) == dst)
                return 1'b1;
        return 1'b0;
    endfunction

    // Every 4-bit id is a valid node here, so the out-of-range answers never arise.
    function automatic void predict_answers(afr_in_t req);
        int                src;
        int                dst;
        int                cnt;
        int                hit;
        int                nb;
        logic [NODE_W-1:0] cand;
        logic [NODE_W-1:0] picks [$];
        afr_out_t          ans;
        src = int'(req.first_node);
        dst = int'(req.second_node);
        cnt = nbr_cnt[src];
        ans = '{ST_DONE, '0, 1'b1};
        case (req.command)
            CMD_CLEAR:
                nbr_cnt[src] = 0;
            CMD_ADD:
            begin
                if (is_linked(src, dst))
                    ans.status = ST_DUP;
                else if (cnt >= NODES)
                    ans.status = ST_FULL;
                else
                begin
                    nbr_ids[src][cnt] = NODE_W'(dst);
                    nbr_cnt[src] = cnt + 1;
                end
            end
            CMD_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < cnt; i++)
                    if (hit < 0 && int'(nbr_ids[src][i]) == dst)
                        hit = i;
                if (hit < 0)
                    ans.status = ST_MISSING;
                else
                begin
                    for (int j = hit; j + 1 < cnt; j++)
                        nbr_ids[src][j] = nbr_ids[src][j + 1];
                    nbr_cnt[src] = cnt - 1;
                end
            end
            default:
            begin
                for (int i = 0; i < cnt; i++)
                begin
                    nb = int'(nbr_ids[src][i]);
                    for (int j = 0; j < nbr_cnt[nb]; j++)
                    begin
                        cand = nbr_ids[nb][j];
                        if (picks.size() < MAX_OUT && int'(cand) != src
                            && !is_linked(src, int'(cand))
                            && !already_suggested[src][cand])
                        begin
                            already_suggested[src][cand] = 1'b1;
                            picks.push_back(cand);
                        end
                    end
                end
                if (picks.size() == 0)
                    ans.status = ST_NONE;
            end
        endcase
        if (picks.size() == 0)
            due_answers.push_back(ans);
        else
            for (int k = 0; k < picks.size(); k++)
                due_answers.push_back('{ST_RECO, picks[k], k == picks.size() - 1});
    endfunction

    task automatic queue_cmd(afr_cmd_t cmd, int a, int b);
        afr_in_t req;
        req.command     = cmd;
        req.first_node  = NODE_W'(a);
        req.second_node = NODE_W'(b);
        cmd_backlog.push_back(req);
        issued++;
        if (cmd == CMD_ADD)
            gen_link[a][b] = 1'b1;
        else if (cmd == CMD_REMOVE)
            gen_link[a][b] = 1'b0;
        else if (cmd == CMD_CLEAR)
            for (int i = 0; i < NODES; i++)
                gen_link[a][i] = 1'b0;
    endtask

    // Clear one node, give it every id in shuffled order, then poke at the full list.
    task automatic queue_full_list(int node);
        int order [NODES];
        int pick;
        int tmp;
        for (int i = 0; i < NODES; i++)
            order[i] = i;
        for (int i = NODES - 1; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        queue_cmd(CMD_CLEAR, node, $urandom_range(0, 15));
        for (int i = 0; i < NODES; i++)
            queue_cmd(CMD_ADD, node, order[i]);
        queue_cmd(CMD_ADD, node, $urandom_range(0, 15));
        queue_cmd(CMD_RECO, node, $urandom_range(0, 15));
        queue_cmd(CMD_REMOVE, node, order[$urandom_range(1, NODES - 2)]);
    endtask

    task automatic queue_random_cmd();
        int r;
        int a;
        int b;
        int tries;
        r = $urandom_range(0, 99);
        a = $urandom_range(0, 15);
        b = $urandom_range(0, 15);
        if (r < 45)
            queue_cmd(CMD_ADD, a, b);
        else if (r < 60)
        begin
            // Removals are redrawn, at random and up to 64 times, to target a link that exists.
            tries = 0;
            while ($urandom_range(0, 9) < 7 && !gen_link[a][b] && tries < 64)
            begin
                a = $urandom_range(0, 15);
                b = $urandom_range(0, 15);
                tries++;
            end
            queue_cmd(CMD_REMOVE, a, b);
        end
        else if (r < 67)
            queue_cmd(CMD_CLEAR, a, b);
        else
            queue_cmd(CMD_RECO, a, b);
    endtask

    initial
    begin
        for (int i = 0; i < NODES; i++)
        begin
            nbr_cnt[i] = 0;
            for (int j = 0; j < NODES; j++)
            begin
                nbr_ids[i][j] = '0;
                already_suggested[i][j] = 1'b0;
                gen_link[i][j] = 1'b0;
            end
        end
        for (int i = 0; i < 4; i++)
            cmd_seen[i] = 0;

        // Directed part: duplicates, self links, removal from the middle, empty and
        // exhausted recommendations, clears that keep the marks, extreme ids.
        queue_cmd(CMD_CLEAR, 0, 15);
        queue_cmd(CMD_ADD, 0, 1);
        queue_cmd(CMD_ADD, 0, 1);
        queue_cmd(CMD_ADD, 0, 0);
        queue_cmd(CMD_ADD, 0, 15);
        queue_cmd(CMD_ADD, 1, 2);
        queue_cmd(CMD_ADD, 1, 3);
        queue_cmd(CMD_ADD, 1, 0);
        queue_cmd(CMD_ADD, 15, 14);
        queue_cmd(CMD_ADD, 15, 2);
        queue_cmd(CMD_RECO, 0, 9);
        queue_cmd(CMD_RECO, 0, 0);
        queue_cmd(CMD_REMOVE, 0, 0);
        queue_cmd(CMD_REMOVE, 0, 7);
        queue_cmd(CMD_RECO, 1, 15);
        queue_cmd(CMD_CLEAR, 1, 0);
        queue_cmd(CMD_RECO, 1, 0);
        queue_cmd(CMD_RECO, 12, 5);
        queue_cmd(CMD_REMOVE, 15, 14);
        queue_cmd(CMD_ADD, 15, 14);
        queue_cmd(CMD_CLEAR, 15, 15);
        queue_cmd(CMD_ADD, 15, 0);
        queue_cmd(CMD_RECO, 15, 15);

        while (issued < TARGET_REQS)
        begin
            if ($urandom_range(0, 99) < 4)
                queue_full_list($urandom_range(0, 15));
            else
                queue_random_cmd();
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid);
        while (due_answers.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Summary: %0d requests (clear %0d, add %0d, remove %0d, recommend %0d)",
                 cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
                 cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("Summary: %0d results checked, %0d of them suggested ids",
                 results_checked, ids_suggested);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Request driver.
    always @(negedge clk)
    begin : drive_requests
        logic    nxt_valid;
        afr_in_t nxt_req;
        nxt_valid = cmd_valid;
        nxt_req   = cmd_req;
        if (rst_n)
        begin
            if (cmd_valid && req_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (cmd_backlog.size() != 0)
                begin
                    nxt_req   = cmd_backlog.pop_front();
                    nxt_valid = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        send_steady = !send_steady;
                    send_gap = send_steady ? 0 : $urandom_range(0, 3);
                end
            end
        end
        cmd_valid <= nxt_valid;
        cmd_req   <= nxt_req;
    end

    // Result receiver; once in the run it holds off long enough for the block to back up.
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                if ($urandom_range(0, 15) == 0)
                    rsp_steady = !rsp_steady;
                rsp_wait = rsp_steady ? 0 : $urandom_range(0, 3);
                if (!hold_done && results_checked >= HOLD_AFTER)
                begin
                    hold_done = 1'b1;
                    rsp_wait  = LONG_HOLD;
                end
            end
            if (rsp_wait > 0)
            begin
                rsp_wait--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge clk)
    begin : watch_ports
        afr_out_t want;
        req_taken <= cmd_valid && cmd_ready;
        rsp_taken <= rsp_valid && rsp_ready;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                cmd_seen[cmd_req.command]++;
                predict_answers(cmd_req);
            end
            if (rsp_valid && rsp_ready)
            begin
                results_checked++;
                if (rsp.status == ST_RECO)
                    ids_suggested++;
                if (due_answers.size() == 0)
                begin
                    error_count++;
                    $error("unexpected result: status %0d suggested_node %0d last_result %0d",
                           rsp.status, rsp.suggested_node, rsp.last_result);
                end
                else
                begin
                    want = due_answers.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        error_count++;
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                    end
                    if (rsp.suggested_node !== want.suggested_node)
                    begin
                        error_count++;
                        $error("suggested_node: expected %0d, got %0d",
                               want.suggested_node, rsp.suggested_node);
                    end
                    if (rsp.last_result !== want.last_result)
                    begin
                        error_count++;
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, rsp.last_result);
                    end
                end
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d results still due",
                     idle_cycles, due_answers.size());
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

### files.f
rtl/afr_pkg.sv
rtl/afr_list_mem.sv
rtl/afr_ctrl.sv
rtl/adjacency_friend_recommender.sv
bench/tb_top.sv
